@@ rtl/nns_pkg.sv @@
`timescale 1ns / 1ps

package nns_pkg;

  // width of a size register and of every coordinate and remainder
  localparam int CFG_W = 9;
  // width used to carry a size limit (up to 4096)
  localparam int SIZE_W = 13;
  localparam int PIXEL_BITS = 16;

  localparam logic [CFG_W-1:0] RESET_SIZE = 9'd256;

  // item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EMIT = 1'b1;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                  mode;
    logic [PIXEL_BITS-1:0] src_pixel;
  } nns_in_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] dst_pixel;
    logic                  frame_end;
  } nns_out_t;

  // integer and fractional step of the source coordinates per destination step
  typedef struct packed {
    logic [CFG_W-1:0] col_quot;
    logic [CFG_W-1:0] col_rem;
    logic [CFG_W-1:0] row_quot;
    logic [CFG_W-1:0] row_rem;
  } nns_scale_t;

  // zero acts as one, anything above the limit acts as the limit
  function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v,
                                                 input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] wide;
    logic [CFG_W-1:0]  res;
    wide = SIZE_W'(v);
    if (v == '0) begin
      res = CFG_W'(1);
    end else if (wide > maxv) begin
      res = maxv[CFG_W-1:0];
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

@@ rtl/nearest_neighbor_image_scaler.sv @@
`timescale 1ns / 1ps

// Nearest-neighbor image scaler.
// Command channel: an item is taken when start is high and busy is low.
// A load item (mode 0) writes src_pixel at the next raster position of the
// frame store; the position wraps after src_width*src_height pixels. An emit
// item (mode 1) returns the next destination pixel, with frame_end set on the
// last pixel of the destination frame; emission then wraps.
// Loads do not make the block busy, so loads can be issued back to back. An emit
// item forms its address at the accept edge, the frame store is read in state
// S_READ, and the result strobe res_valid_o is high in state S_OUT after that,
// unless a configuration write comes between. The registered emit address and
// the registered frame store read lie between the accept edge and the result.
// Results last one cycle and cannot be held off by the receiver.
// Configuration writes restart both load and emission positions, then two
// dividers find the coordinate steps; busy stays high until both are done.
// After reset the same setup runs with all sizes at 256 (or the maximum).
// The frame store is not cleared: a whole source frame must be loaded first.
module nearest_neighbor_image_scaler import nns_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  nns_in_t          item_i,
  output logic             res_valid_o,
  output nns_out_t         res_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = 2 * CFG_W;
  localparam logic [SIZE_W-1:0] MAX_W_L = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] MAX_H_L = SIZE_W'(MAX_HEIGHT);
  localparam logic [CFG_W-1:0]  RST_W   = eff_size(RESET_SIZE, MAX_W_L);
  localparam logic [CFG_W-1:0]  RST_H   = eff_size(RESET_SIZE, MAX_H_L);
  localparam logic [FW-1:0]     RST_FRAME = FW'(int'(RST_W) * int'(RST_H));

  typedef enum logic [3:0] {
    S_DIV  = 4'b0001,
    S_IDLE = 4'b0010,
    S_READ = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic             kick_q;
  logic [CFG_W-1:0] sw_q, sh_q, dw_q, dh_q;
  logic [FW-1:0]    frame_size_q;
  logic [AW-1:0]    load_pos_q, load_pos_d;
  logic [AW-1:0]    addr_q;
  logic             last_q;
  logic             cfg_we, accept, load, emit;
  logic             col_busy, row_busy;
  nns_scale_t       scale;
  logic [AW-1:0]    coord_addr;
  logic             coord_last;
  logic [PIXEL_BITS-1:0] rd_data;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign load        = accept && (item_i.mode == MODE_LOAD);
  assign emit        = accept && (item_i.mode == MODE_EMIT);

  // size registers, stored already clamped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= RST_W;
      sh_q <= RST_H;
      dw_q <= RST_W;
      dh_q <= RST_H;
    end else if (cfg_we) begin
      case (cfg_idx_i)
        REG_SRC_WIDTH:  sw_q <= eff_size(cfg_data_i, MAX_W_L);
        REG_SRC_HEIGHT: sh_q <= eff_size(cfg_data_i, MAX_H_L);
        REG_DST_WIDTH:  dw_q <= eff_size(cfg_data_i, MAX_W_L);
        REG_DST_HEIGHT: dh_q <= eff_size(cfg_data_i, MAX_H_L);
        default: ;
      endcase
    end
  end

  // source frame size, used for the load wrap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_size_q <= RST_FRAME;
    end else begin
      frame_size_q <= sw_q * sh_q;
    end
  end

  // load position
  always_comb begin
    load_pos_d = load_pos_q;
    if (cfg_we) begin
      load_pos_d = '0;
    end else if (load) begin
      if ((32'(load_pos_q) + 32'd1) >= 32'(frame_size_q)) begin
        load_pos_d = '0;
      end else begin
        load_pos_d = load_pos_q + AW'(1);
      end
    end
  end

  // control sequence
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_DIV: begin
        if (!kick_q && !col_busy && !row_busy) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (emit) begin
          state_d = S_READ;
        end
      end
      S_READ:  state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_DIV;
    endcase
    if (cfg_we) begin
      state_d = S_DIV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_DIV;
      kick_q     <= 1'b1;
      load_pos_q <= '0;
    end else begin
      state_q    <= state_d;
      kick_q     <= cfg_we;
      load_pos_q <= load_pos_d;
    end
  end

  // read address and frame end flag of the emitted item
  always_ff @(posedge clk_i) begin
    if (emit) begin
      addr_q <= coord_addr;
      last_q <= coord_last;
    end
  end

  // coordinate steps: src / dst for columns and rows
  nns_div u_col_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (kick_q),
    .dividend_i (sw_q),
    .divisor_i  (dw_q),
    .busy_o     (col_busy),
    .quot_o     (scale.col_quot),
    .rem_o      (scale.col_rem)
  );

  nns_div u_row_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (kick_q),
    .dividend_i (sh_q),
    .divisor_i  (dh_q),
    .busy_o     (row_busy),
    .quot_o     (scale.row_quot),
    .rem_o      (scale.row_rem)
  );

  nns_coord #(
    .AW (AW)
  ) u_coord (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_we),
    .advance_i (emit),
    .sw_i      (sw_q),
    .dw_i      (dw_q),
    .dh_i      (dh_q),
    .scale_i   (scale),
    .addr_o    (coord_addr),
    .last_o    (coord_last)
  );

  // frame store
  nns_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (load),
    .waddr_i (load_pos_q),
    .wdata_i (item_i.src_pixel),
    .re_i    (state_q == S_READ),
    .raddr_i (addr_q),
    .rdata_o (rd_data)
  );

  // result item
  always_comb begin
    res_valid_o     = (state_q == S_OUT);
    res_o.dst_pixel = rd_data;
    res_o.frame_end = last_q;
  end

  a_emit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !cfg_we) ##1 !cfg_we |=> res_valid_o)
    else $error("emit item gave no result two cycles later");

  a_load_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (32'(load_pos_q) < 32'(frame_size_q)))
    else $error("load position beyond source frame");

  a_idle_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!col_busy && !row_busy && !kick_q))
    else $error("idle while coordinate steps still being computed");

endmodule

@@ rtl/nns_ram.sv @@
`timescale 1ns / 1ps

module nns_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/nns_div.sv @@
`timescale 1ns / 1ps

module nns_div import nns_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CFG_W-1:0] dividend_i,
  input  logic [CFG_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [CFG_W-1:0] quot_o,
  output logic [CFG_W-1:0] rem_o
);

  localparam int CW = $clog2(CFG_W + 1);

  logic             busy_q, busy_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CFG_W-1:0] quot_q, rem_q, div_q;
  logic [CFG_W:0]   shifted;
  logic             fits;

  // one quotient bit per cycle, restoring
  assign shifted = {rem_q, quot_q[CFG_W-1]};
  assign fits    = shifted >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(CFG_W);
    end else if (busy_q) begin
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[CFG_W-2:0], fits};
      rem_q  <= fits ? CFG_W'(shifted - {1'b0, div_q}) : shifted[CFG_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

@@ rtl/nns_coord.sv @@
`timescale 1ns / 1ps

module nns_coord import nns_pkg::*; #(
  parameter int AW = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             restart_i,
  input  logic             advance_i,
  input  logic [CFG_W-1:0] sw_i,
  input  logic [CFG_W-1:0] dw_i,
  input  logic [CFG_W-1:0] dh_i,
  input  nns_scale_t       scale_i,
  output logic [AW-1:0]    addr_o,
  output logic             last_o
);

  logic [CFG_W-1:0]   dcol_q, dcol_d, drow_q, drow_d;
  logic [CFG_W-1:0]   scol_q, scol_d, srow_q, srow_d;
  logic [CFG_W-1:0]   crem_q, crem_d, rrem_q, rrem_d;
  logic [CFG_W:0]     dcol_inc, drow_inc;
  logic [CFG_W:0]     csum, rsum;
  logic               col_end, row_end, c_carry, r_carry;
  logic [2*CFG_W-1:0] prod;
  logic [2*CFG_W:0]   idx;

  // end of line and end of frame
  assign dcol_inc = {1'b0, dcol_q} + (CFG_W+1)'(1);
  assign drow_inc = {1'b0, drow_q} + (CFG_W+1)'(1);
  assign col_end  = dcol_inc >= {1'b0, dw_i};
  assign row_end  = drow_inc >= {1'b0, dh_i};
  assign last_o   = col_end && row_end;

  // remainder steps, carry adds one to the source coordinate
  assign csum    = {1'b0, crem_q} + {1'b0, scale_i.col_rem};
  assign rsum    = {1'b0, rrem_q} + {1'b0, scale_i.row_rem};
  assign c_carry = csum >= {1'b0, dw_i};
  assign r_carry = rsum >= {1'b0, dh_i};

  always_comb begin
    dcol_d = dcol_q;
    drow_d = drow_q;
    scol_d = scol_q;
    srow_d = srow_q;
    crem_d = crem_q;
    rrem_d = rrem_q;
    if (restart_i) begin
      dcol_d = '0;
      drow_d = '0;
      scol_d = '0;
      srow_d = '0;
      crem_d = '0;
      rrem_d = '0;
    end else if (advance_i) begin
      if (col_end) begin
        dcol_d = '0;
        scol_d = '0;
        crem_d = '0;
        if (row_end) begin
          drow_d = '0;
          srow_d = '0;
          rrem_d = '0;
        end else begin
          drow_d = drow_inc[CFG_W-1:0];
          srow_d = srow_q + scale_i.row_quot + CFG_W'(r_carry);
          rrem_d = r_carry ? CFG_W'(rsum - {1'b0, dh_i}) : rsum[CFG_W-1:0];
        end
      end else begin
        dcol_d = dcol_inc[CFG_W-1:0];
        scol_d = scol_q + scale_i.col_quot + CFG_W'(c_carry);
        crem_d = c_carry ? CFG_W'(csum - {1'b0, dw_i}) : csum[CFG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcol_q <= '0;
      drow_q <= '0;
      scol_q <= '0;
      srow_q <= '0;
      crem_q <= '0;
      rrem_q <= '0;
    end else begin
      dcol_q <= dcol_d;
      drow_q <= drow_d;
      scol_q <= scol_d;
      srow_q <= srow_d;
      crem_q <= crem_d;
      rrem_q <= rrem_d;
    end
  end

  // raster address of the current source pixel
  assign prod   = srow_q * sw_i;
  assign idx    = {1'b0, prod} + (2*CFG_W+1)'(scol_q);
  assign addr_o = AW'(idx);

  a_scol_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scol_q < sw_i)
    else $error("source column beyond source width");

  a_dest_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dcol_q < dw_i) && (drow_q < dh_i))
    else $error("destination position outside destination frame");

endmodule

@@ tb/nearest_neighbor_image_scaler_test.sv @@
`timescale 1ns / 1ps

module nearest_neighbor_image_scaler_test;
  import nns_pkg::*;

  localparam int     MAX_SIDE    = 256;
  localparam int     STORE_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int     NUM_ITEMS   = 1600;
  localparam int     SETTLE      = 4;
  localparam longint LIMIT       = 1_000_000;

  // tracks frame store, sizes and scan position; holds the pixels still due
  class scaler_scoreboard;
    logic [CFG_W-1:0]      src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic [PIXEL_BITS-1:0] frame_store [STORE_DEPTH];
    logic [15:0]           load_pos;
    logic [CFG_W-1:0]      dst_col, dst_row, src_col, src_row, col_rem, row_rem;
    nns_out_t              due_pixels [$];
    int                    fails;

    function new();
      src_w_reg = RESET_SIZE;
      src_h_reg = RESET_SIZE;
      dst_w_reg = RESET_SIZE;
      dst_h_reg = RESET_SIZE;
      fails     = 0;
      restart_frame();
    endfunction

    // zero acts as one, anything past the store side is clamped
    function int unsigned effective(logic [CFG_W-1:0] v);
      if (v == '0) return 1;
      if (v > MAX_SIDE) return MAX_SIDE;
      return 32'(v);
    endfunction

    function void restart_frame();
      load_pos = '0;
      dst_col  = '0;
      dst_row  = '0;
      src_col  = '0;
      src_row  = '0;
      col_rem  = '0;
      row_rem  = '0;
    endfunction

    function void write_size_reg(cfg_reg_e r, logic [CFG_W-1:0] v);
      case (r)
        REG_SRC_WIDTH:  src_w_reg = v;
        REG_SRC_HEIGHT: src_h_reg = v;
        REG_DST_WIDTH:  dst_w_reg = v;
        REG_DST_HEIGHT: dst_h_reg = v;
        default: ;
      endcase
      restart_frame();
    endfunction

    function int unsigned source_pixels();
      return effective(src_w_reg) * effective(src_h_reg);
    endfunction

    function int pending();
      return due_pixels.size();
    endfunction

    // apply one accepted item; an emit queues the pixel it must return
    function void note_item(nns_in_t it);
      int unsigned sw, sh, dw, dh, acc, addr;
      nns_out_t    px;
      sw = effective(src_w_reg);
      sh = effective(src_h_reg);
      dw = effective(dst_w_reg);
      dh = effective(dst_h_reg);
      if (it.mode == MODE_LOAD) begin
        frame_store[load_pos] = it.src_pixel;
        acc = load_pos + 1;
        load_pos = (acc >= sw * sh) ? '0 : acc[15:0];
        return;
      end
      addr = src_row * sw + src_col;
      px.dst_pixel = frame_store[addr[15:0]];
      px.frame_end = (dst_col + 1 >= dw) && (dst_row + 1 >= dh);
      due_pixels.push_back(px);
      // step to the next destination pixel with quotient/remainder tracking
      acc = dst_col + 1;
      if (acc >= dw) begin
        dst_col = '0;
        src_col = '0;
        col_rem = '0;
        acc = dst_row + 1;
        if (acc >= dh) begin
          dst_row = '0;
          src_row = '0;
          row_rem = '0;
        end else begin
          dst_row = acc[CFG_W-1:0];
          acc = row_rem + sh;
          src_row = src_row + CFG_W'(acc / dh);
          row_rem = CFG_W'(acc % dh);
        end
      end else begin
        dst_col = acc[CFG_W-1:0];
        acc = col_rem + sw;
        src_col = src_col + CFG_W'(acc / dw);
        col_rem = CFG_W'(acc % dw);
      end
    endfunction

    function void check_result(nns_out_t got);
      nns_out_t want;
      if (due_pixels.size() == 0) begin
        $display("%0t: unexpected pixel %h frame_end %b", $time, got.dst_pixel,
                 got.frame_end);
        fails++;
        return;
      end
      want = due_pixels.pop_front();
      if (got.dst_pixel !== want.dst_pixel) begin
        $display("%0t: dst_pixel expected %h actual %h", $time, want.dst_pixel,
                 got.dst_pixel);
        fails++;
      end
      if (got.frame_end !== want.frame_end) begin
        $display("%0t: frame_end expected %b actual %b", $time, want.frame_end,
                 got.frame_end);
        fails++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start;
  logic             busy;
  nns_in_t          item_i;
  logic             res_valid_o;
  nns_out_t         res_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [1:0]       cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  scaler_scoreboard sb;
  int               sent_items  = 0;
  longint           cycle_count = 0;

  nearest_neighbor_image_scaler u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // result strobe lasts one cycle, checked at the edge that ends it
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      sb.check_result(res_o);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("[nearest_neighbor_image_scaler] ERROR");
      $finish;
    end
  end

  // hand one item to the block; start stays high so items can go back to back
  task automatic send_item(input logic mode, input logic [PIXEL_BITS-1:0] pixel);
    int unsigned idle_pct;
    nns_in_t     it;
    idle_pct = (sent_items < NUM_ITEMS / 3)     ? 12 :
               (sent_items < 2 * NUM_ITEMS / 3) ? 60 : 0;
    it.mode      = mode;
    it.src_pixel = pixel;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_item(it);
    sent_items++;
  endtask

  // quiet the command side and let the last emit finish
  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_sizes(input logic [CFG_W-1:0] sw, sh, dw, dh);
    cfg_reg_e         regs [4];
    logic [CFG_W-1:0] vals [4];
    int               i;
    regs = '{REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_DST_WIDTH, REG_DST_HEIGHT};
    vals = '{sw, sh, dw, dh};
    wait_drained();
    cfg_valid_i <= 1'b1;
    for (i = 0; i < 4; i++) begin
      cfg_idx_i  <= regs[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      sb.write_size_reg(regs[i], vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // fill every source entry so no emit reads an unwritten location
  task automatic load_frame();
    int unsigned n;
    n = sb.source_pixels();
    repeat (n) begin
      if (sent_items < NUM_ITEMS) send_item(MODE_LOAD, PIXEL_BITS'($urandom));
    end
  endtask

  function automatic logic [CFG_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) return '0;
    if (r < 12) return CFG_W'(256);
    if (r < 16) return CFG_W'($urandom_range(257, 511));
    if (r < 20) return CFG_W'(255);
    return CFG_W'($urandom_range(1, 12));
  endfunction

  initial begin
    logic [PIXEL_BITS-1:0] corner_px [7];
    logic [CFG_W-1:0]      sw, sh, dw, dh;
    int                    mix_len;
    int                    drain;
    corner_px   = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001,
                    16'h5555, 16'hAAAA, 16'h1234};
    sb          = new();
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_valid_i = 1'b0;
    cfg_idx_i   = REG_SRC_WIDTH;
    cfg_data_i  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // upscale 3x2 to 4x3; seventh load wraps onto the first entry
    set_sizes(9'd3, 9'd2, 9'd4, 9'd3);
    foreach (corner_px[i]) send_item(MODE_LOAD, corner_px[i]);
    repeat (14) send_item(MODE_EMIT, PIXEL_BITS'($urandom));

    // zero sizes act as a single pixel frame
    set_sizes('0, '0, '0, '0);
    send_item(MODE_LOAD, 16'h8001);
    repeat (2) send_item(MODE_EMIT, 16'hFFFF);

    // oversized width clamps to the store side; short source keeps the load short
    set_sizes(9'd511, 9'd2, 9'd5, 9'd9);
    load_frame();
    repeat (50) send_item(MODE_EMIT, PIXEL_BITS'($urandom));

    // random sizes, full frame load, then mixed loads and emits
    while (sent_items < NUM_ITEMS) begin
      sw = pick_size();
      sh = pick_size();
      dw = pick_size();
      dh = pick_size();
      if (sb.effective(sw) * sb.effective(sh) > 512) sh = CFG_W'($urandom_range(1, 2));
      if (sb.effective(dw) * sb.effective(dh) > 1024) dh = CFG_W'($urandom_range(1, 3));
      set_sizes(sw, sh, dw, dh);
      load_frame();
      mix_len = $urandom_range(40, 160);
      repeat (mix_len) begin
        if (sent_items < NUM_ITEMS) begin
          if ($urandom_range(99) < 70) begin
            send_item(MODE_EMIT, PIXEL_BITS'($urandom));
          end else begin
            send_item(MODE_LOAD, PIXEL_BITS'($urandom));
          end
        end
      end
    end

    // drain what is still in flight
    start <= 1'b0;
    drain = 0;
    while (sb.pending() != 0 && drain < 100) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (2 * SETTLE) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $display("%0t: %0d pixels never returned", $time, sb.pending());
      sb.fails++;
    end
    if (sb.fails == 0) begin
      $display("[nearest_neighbor_image_scaler] OK");
    end else begin
      $display("[nearest_neighbor_image_scaler] ERROR");
    end
    $finish;
  end

endmodule
